// ----- sv/utf8dv_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decode/validate package
// Word types for the byte and result channels, and the decode constants.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8dv_pkg;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       end_of_text;
   } req_word_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic [2:0]  seq_len;
      logic        bad;
      logic        final_flag;
   } rsp_word_type;

   localparam logic [20:0] SURR_LO  = 21'h00D800;
   localparam logic [20:0] SURR_HI  = 21'h00DFFF;
   localparam logic [20:0] MAX_LEN1 = 21'h00007F;
   localparam logic [20:0] MAX_LEN2 = 21'h0007FF;
   localparam logic [20:0] MAX_LEN3 = 21'h00FFFF;

   localparam logic [2:0] LEN_ONE   = 3'd1;
   localparam logic [2:0] LEN_TWO   = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR  = 3'd4;

   // Shortest encoding length for a code point.
   function automatic logic [2:0] min_len(input logic [20:0] cp);
      logic [2:0] len;
      if (cp <= MAX_LEN1) begin
         len = LEN_ONE;
      end else if (cp <= MAX_LEN2) begin
         len = LEN_TWO;
      end else if (cp <= MAX_LEN3) begin
         len = LEN_THREE;
      end else begin
         len = LEN_FOUR;
      end
      return len;
   endfunction

endpackage

`default_nettype wire

// ----- sv/utf8dv_in_stage.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decode/validate input stage
// Holds one incoming byte word until the decode stage consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8dv_in_stage (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  utf8dv_pkg::req_word_type req_word,
   input  wire                      take,
   output logic                     held_valid,
   output utf8dv_pkg::req_word_type held_word
);
   import utf8dv_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_word_type word_ff;

   // The register can load whenever it is empty or its word leaves this cycle.
   assign req_stall  = valid_ff && !take;
   assign valid_in   = req_stall ? valid_ff : req_valid;
   assign held_valid = valid_ff;
   assign held_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         word_ff <= req_word;
      end
   end

endmodule

`default_nettype wire

// ----- sv/utf8dv_decode.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decode/validate sequence decoder
// Tracks the sequence in progress and forms the result for each byte.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8dv_decode (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      step,
   input  utf8dv_pkg::req_word_type word,
   output logic                     emit,
   output utf8dv_pkg::rsp_word_type result
);
   import utf8dv_pkg::*;

   logic [20:0] accum_ff;
   logic [20:0] accum_in;
   logic [1:0]  left_ff;
   logic [1:0]  left_in;
   logic [2:0]  len_ff;
   logic [2:0]  len_in;
   logic        failed_ff;
   logic        failed_in;

   logic [7:0]  b;
   logic        last;
   logic [20:0] acc_shift;
   logic        err;
   logic        done;
   logic [20:0] cp;
   logic [2:0]  slen;

   assign b         = word.byte_in;
   assign last      = word.end_of_text;
   assign acc_shift = {accum_ff[14:0], b[5:0]};

   always_comb begin
      accum_in  = accum_ff;
      left_in   = left_ff;
      len_in    = len_ff;
      failed_in = failed_ff;
      emit      = 1'b0;
      result    = '0;
      err       = 1'b0;
      done      = 1'b0;
      cp        = '0;
      slen      = '0;

      if (failed_ff) begin
         // After an error only the last byte of the string reports.
         if (last) begin
            emit              = 1'b1;
            result.bad        = 1'b1;
            result.final_flag = 1'b1;
            failed_in         = 1'b0;
         end
      end else begin
         if (left_ff == 2'd0) begin
            if (!b[7]) begin
               done = 1'b1;
               cp   = {13'd0, b};
               slen = LEN_ONE;
            end else if (b[7:5] == 3'b110) begin
               accum_in = {16'd0, b[4:0]};
               left_in  = 2'd1;
               len_in   = LEN_TWO;
            end else if (b[7:4] == 4'b1110) begin
               accum_in = {17'd0, b[3:0]};
               left_in  = 2'd2;
               len_in   = LEN_THREE;
            end else if (b[7:3] == 5'b11110) begin
               accum_in = {18'd0, b[2:0]};
               left_in  = 2'd3;
               len_in   = LEN_FOUR;
            end else begin
               err = 1'b1;
            end
         end else if (b[7:6] == 2'b10) begin
            accum_in = acc_shift;
            left_in  = left_ff - 2'd1;
            if (left_ff == 2'd1) begin
               cp   = acc_shift;
               slen = len_ff;
               if (acc_shift >= SURR_LO && acc_shift <= SURR_HI) begin
                  err = 1'b1;
               end else if (min_len(acc_shift) != len_ff) begin
                  err = 1'b1;
               end else begin
                  done = 1'b1;
               end
            end
         end else begin
            err = 1'b1;
         end

         if (err) begin
            emit              = 1'b1;
            result.bad        = 1'b1;
            result.final_flag = last;
            failed_in         = !last;
         end else if (done) begin
            emit              = 1'b1;
            result.code_point = cp;
            result.seq_len    = slen;
            result.final_flag = last;
         end else if (last) begin
            // The string ended inside a sequence.
            emit              = 1'b1;
            result.bad        = 1'b1;
            result.final_flag = 1'b1;
         end

         if (err || done || last) begin
            accum_in = '0;
            left_in  = '0;
            len_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff  <= '0;
         left_ff   <= '0;
         len_ff    <= '0;
         failed_ff <= 1'b0;
      end else if (step) begin
         accum_ff  <= accum_in;
         left_ff   <= left_in;
         len_ff    <= len_in;
         failed_ff <= failed_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/utf8dv_out_stage.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decode/validate output stage
// Result register that holds a word until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8dv_out_stage (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      load,
   input  utf8dv_pkg::rsp_word_type load_word,
   output logic                     ready,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output utf8dv_pkg::rsp_word_type rsp_word
);
   import utf8dv_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;

   assign ready     = !valid_ff || !rsp_stall;
   assign valid_in  = ready ? load : valid_ff;
   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && load) begin
         word_ff <= load_word;
      end
   end

endmodule

`default_nettype wire

// ----- sv/utf8_decode_validate_unit.sv -----
// A result word reaches rsp_word through the input register, then the result
// register; the decode between them is combinational.
// Throughput: one byte per cycle while rsp_stall does not hold the result register.
// Bytes inside a sequence and bytes after an error yield no result word
// unless they end the string. Reset (synchronous, active high) empties both
// registers and clears the sequence state, so the next byte starts a string.
// ----------------------------------------------------------------------------
// UTF-8 decoder and validator
// Decodes a byte stream into code points and flags invalid strings.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_decode_validate_unit (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  utf8dv_pkg::req_word_type req_word,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output utf8dv_pkg::rsp_word_type rsp_word
);
   import utf8dv_pkg::*;

   logic         held_valid;
   req_word_type held_word;
   logic         emit;
   rsp_word_type dec_word;
   logic         out_ready;
   logic         take;

   // A byte leaves the input register when its result, if any, has room.
   assign take = held_valid && (!emit || out_ready);

   utf8dv_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .take       (take),
      .held_valid (held_valid),
      .held_word  (held_word)
   );

   utf8dv_decode u_dec (
      .clock  (clock),
      .reset  (reset),
      .step   (take),
      .word   (held_word),
      .emit   (emit),
      .result (dec_word)
   );

   utf8dv_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (take && emit),
      .load_word (dec_word),
      .ready     (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 decode/validate unit testbench
// Feeds byte strings through the decoder and checks every result word
// against a cycle-free software decoder of the same rules. Directed strings
// cover the code point extremes and each kind of invalid input. Random
// strings are mostly well-formed text with some broken sequences and noise
// mixed in. Both sides of the block idle at random, and one stretch holds
// the result side off long enough to stall the byte side.
// ----------------------------------------------------------------------------

module tb;
   import utf8dv_pkg::*;

   localparam int          STALL_LIMIT  = 400;
   localparam int          HOLD_CYCLES  = 40;
   localparam int          DRAIN_CYCLES = 10;
   localparam int          MAX_REPORTS  = 10;
   localparam int          RANDOM_BYTES = 800;
   localparam logic [20:0] CP_TOP       = 21'h1FFFFF;
   localparam logic [7:0]  CONT_MIN     = 8'h80;
   localparam logic [7:0]  CONT_MAX     = 8'hBF;
   localparam logic [7:0]  LEAD2_MIN    = 8'hC0;
   localparam logic [7:0]  LEAD2_MAX    = 8'hDF;
   localparam logic [7:0]  LEAD3_MIN    = 8'hE0;
   localparam logic [7:0]  LEAD3_MAX    = 8'hEF;
   localparam logic [7:0]  LEAD4_MIN    = 8'hF0;
   localparam logic [7:0]  LEAD4_MAX    = 8'hF7;
   localparam logic [1:0]  CONT_TAG     = 2'b10;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   // Decoder state as the block should hold it.
   logic [20:0]  dec_accum = '0;
   logic [1:0]   dec_left = '0;
   logic [2:0]   dec_len = '0;
   logic         dec_failed = 1'b0;

   rsp_word_type pending_points[$];
   logic [7:0]   text_bytes[$];
   int           err_count = 0;
   bit           tx_idle = 1'b1;
   bit           rx_idle = 1'b1;
   logic         hold_request = 1'b0;

   utf8_decode_validate_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Work out the result word, if any, that one accepted byte causes.
   task automatic decode_byte(input req_word_type w);
      logic [7:0]   b;
      logic         last;
      logic         err;
      logic         done;
      logic         give;
      logic         bad;
      logic [20:0]  cp;
      logic [2:0]   len;
      logic [2:0]   shortest;
      rsp_word_type r;
      b = w.byte_in;
      last = w.end_of_text;
      err = 1'b0;
      done = 1'b0;
      give = 1'b0;
      bad = 1'b0;
      cp = '0;
      len = '0;
      if (dec_failed) begin
         give = last;
         bad = 1'b1;
      end else begin
         if (dec_left == 2'd0) begin
            if (b < CONT_MIN) begin
               cp = {13'd0, b};
               len = LEN_ONE;
               done = 1'b1;
            end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
               dec_accum = {16'd0, b[4:0]};
               dec_left = 2'd1;
               dec_len = LEN_TWO;
            end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
               dec_accum = {17'd0, b[3:0]};
               dec_left = 2'd2;
               dec_len = LEN_THREE;
            end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
               dec_accum = {18'd0, b[2:0]};
               dec_left = 2'd3;
               dec_len = LEN_FOUR;
            end else begin
               err = 1'b1;
            end
         end else if (b >= CONT_MIN && b <= CONT_MAX) begin
            dec_accum = {dec_accum[14:0], b[5:0]};
            dec_left = dec_left - 2'd1;
            if (dec_left == 2'd0) begin
               shortest = (dec_accum <= MAX_LEN1) ? LEN_ONE :
                          (dec_accum <= MAX_LEN2) ? LEN_TWO :
                          (dec_accum <= MAX_LEN3) ? LEN_THREE : LEN_FOUR;
               if (dec_accum >= SURR_LO && dec_accum <= SURR_HI) begin
                  err = 1'b1;
               end else if (shortest != dec_len) begin
                  err = 1'b1;
               end else begin
                  cp = dec_accum;
                  len = dec_len;
                  done = 1'b1;
               end
            end
         end else begin
            err = 1'b1;
         end

         if (err) begin
            give = 1'b1;
            bad = 1'b1;
            dec_failed = 1'b1;
         end else if (done) begin
            give = 1'b1;
         end else if (last) begin
            // The string ended in the middle of a sequence.
            give = 1'b1;
            bad = 1'b1;
         end
      end

      if (give) begin
         r.code_point = cp;
         r.seq_len = len;
         r.bad = bad;
         r.final_flag = last;
         pending_points.push_back(r);
      end
      if (err || done || last) begin
         dec_accum = '0;
         dec_left = '0;
         dec_len = '0;
      end
      if (last) begin
         dec_failed = 1'b0;
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = tx_idle ? $urandom_range(0, 10) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_word.byte_in = b;
      req_word.end_of_text = last;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      decode_byte(req_word);
   endtask

   function automatic logic [20:0] len_ceiling(input int n);
      case (n)
         1:       return MAX_LEN1;
         2:       return MAX_LEN2;
         3:       return MAX_LEN3;
         default: return CP_TOP;
      endcase
   endfunction

   function automatic logic [20:0] len_floor(input int n);
      return (n == 1) ? 21'd0 : len_ceiling(n - 1) + 21'd1;
   endfunction

   function automatic logic [20:0] random_cp(input int n);
      logic [20:0] cp;
      do begin
         cp = 21'($urandom_range(len_floor(n), len_ceiling(n)));
      end while (cp >= SURR_LO && cp <= SURR_HI);
      return cp;
   endfunction

   // Encode cp in exactly n bytes, even where n is longer than needed.
   task automatic append_char(input logic [20:0] cp, input int n);
      case (n)
         1: begin
            text_bytes.push_back({1'b0, cp[6:0]});
         end
         2: begin
            text_bytes.push_back({3'b110, cp[10:6]});
            text_bytes.push_back({CONT_TAG, cp[5:0]});
         end
         3: begin
            text_bytes.push_back({4'b1110, cp[15:12]});
            text_bytes.push_back({CONT_TAG, cp[11:6]});
            text_bytes.push_back({CONT_TAG, cp[5:0]});
         end
         default: begin
            text_bytes.push_back({5'b11110, cp[20:18]});
            text_bytes.push_back({CONT_TAG, cp[17:12]});
            text_bytes.push_back({CONT_TAG, cp[11:6]});
            text_bytes.push_back({CONT_TAG, cp[5:0]});
         end
      endcase
   endtask

   task automatic test_code_point_extremes();
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b1);
      send_byte(8'hC2, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hF7, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b1);
   endtask

   // A stray continuation byte fails the string; the rest is ignored up to
   // the last byte, which still reports. A lone F8 is rejected as a lead byte.
   task automatic test_bad_lead_bytes();
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hF8, 1'b1);
   endtask

   task automatic test_bad_continuation();
      send_byte(8'hC3, 1'b0);
      send_byte(8'h41, 1'b1);
   endtask

   task automatic test_surrogate();
      send_byte(8'hED, 1'b0);
      send_byte(8'hA0, 1'b0);
      send_byte(8'h80, 1'b1);
   endtask

   task automatic test_overlong();
      send_byte(8'hC0, 1'b0);
      send_byte(8'h80, 1'b1);
   endtask

   task automatic test_cut_off_sequence();
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b1);
   endtask

   task automatic test_back_pressure();
      logic [7:0] ch;
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      hold_request = 1'b1;
      ch = 8'h30;
      for (int i = 0; i < 30; i++) begin
         send_byte(ch, i == 29);
         ch = ch + 8'd1;
      end
      while (hold_request) @(posedge clock);
   endtask

   task automatic test_random_strings();
      int live;
      int units;
      int roll;
      int n;
      int cut;
      live = 0;
      while (live < RANDOM_BYTES) begin
         tx_idle = ($urandom_range(0, 3) != 0);
         rx_idle = ($urandom_range(0, 3) != 0);
         units = $urandom_range(1, 10);
         repeat (units) begin
            roll = $urandom_range(0, 99);
            n = $urandom_range(1, 4);
            if (roll < 80) begin
               append_char(random_cp(n), n);
            end else if (roll < 85) begin
               n = $urandom_range(2, 4);
               append_char(21'($urandom_range(0, len_floor(n) - 1)), n);
            end else if (roll < 88) begin
               append_char(21'($urandom_range(SURR_LO, SURR_HI)), 3);
            end else if (roll < 92) begin
               n = $urandom_range(2, 4);
               append_char(random_cp(n), n);
               cut = $urandom_range(1, n - 1);
               repeat (cut) void'(text_bytes.pop_back());
            end else if (roll < 96) begin
               text_bytes.push_back(8'($urandom_range(CONT_MIN, CONT_MAX)));
            end else begin
               text_bytes.push_back(8'($urandom_range(0, 255)));
            end
         end
         for (int i = 0; i < text_bytes.size(); i++) begin
            live++;
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
         end
         text_bytes.delete();
      end
   endtask

   // Receiver: a random hold-off before each word while rx_idle is set, or one long hold on request.
   initial begin : receiver
      int wait_cycles;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         wait_cycles = rx_idle ? $urandom_range(0, 10) : 0;
         if (wait_cycles > 0) begin
            rsp_stall = 1'b1;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin : check_results
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_points.size() == 0) begin
            err_count++;
            if (err_count <= MAX_REPORTS) begin
               $display("unexpected result word: cp=%h len=%0d bad=%b final=%b",
                        rsp_word.code_point, rsp_word.seq_len, rsp_word.bad,
                        rsp_word.final_flag);
            end
         end else begin
            want = pending_points.pop_front();
            if (rsp_word.code_point !== want.code_point ||
                rsp_word.seq_len !== want.seq_len ||
                rsp_word.bad !== want.bad ||
                rsp_word.final_flag !== want.final_flag) begin
               err_count++;
               if (err_count <= MAX_REPORTS) begin
                  $display("mismatch: expected cp=%h len=%0d bad=%b final=%b, %s",
                           want.code_point, want.seq_len, want.bad, want.final_flag,
                           $sformatf("got cp=%h len=%0d bad=%b final=%b",
                                     rsp_word.code_point, rsp_word.seq_len,
                                     rsp_word.bad, rsp_word.final_flag));
               end
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_code_point_extremes();
      test_bad_lead_bytes();
      test_bad_continuation();
      test_surrogate();
      test_overlong();
      test_cut_off_sequence();
      test_back_pressure();
      test_random_strings();

      @(negedge clock);
      req_valid = 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
